FILE: hdl/stable_sort_records_by_key_macros.svh
// assertion macros for the batch record sorter
// used by the top level only, no other dependencies
`ifndef STABLE_SORT_RECORDS_BY_KEY_MACROS_SVH
`define STABLE_SORT_RECORDS_BY_KEY_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SSRK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SSRK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ssrk_pkg.sv
// shared types and constants of the batch record sorter
// no dependencies
`default_nettype none

package ssrk_pkg;

  localparam int unsigned KEY_W             = 20;
  localparam int unsigned TAG_W             = 8;
  localparam int unsigned DEFAULT_MAX_ITEMS = 16;
  // depth of the queue between front and back, power of two
  localparam int unsigned QUEUE_DEPTH       = 4;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [TAG_W-1:0] tag_t;

  typedef struct packed {
    key_t record_key;
    tag_t record_tag;
    logic last_item;
  } in_word_t;

  typedef struct packed {
    key_t sorted_key;
    tag_t sorted_tag;
    logic final_result;
    logic overflowed;
  } out_word_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } rec_t;

  // classified word handed from front to back
  typedef struct packed {
    key_t key;
    tag_t tag;
    logic last;
    logic store;
    logic ovf;
  } q_entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CMP,
    B_PLACE,
    B_EMIT_RD,
    B_EMIT_WAIT
  } back_state_e;

endpackage

`default_nettype wire

FILE: hdl/ssrk_queue.sv
// small queue between the front and back parts of the sorter
// depends on ssrk_pkg
`default_nettype none

module ssrk_queue import ssrk_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire q_entry_t entry_i,
  output q_entry_t      entry_o,
  input  wire logic     pop_i,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         ent_q [QUEUE_DEPTH];
  logic [QAW-1:0]   wptr_q, wptr_d;
  logic [QAW-1:0]   rptr_q, rptr_d;
  logic [QCW-1:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = ent_q[rptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + QAW'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + QAW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ssrk_front.sv
// front part: accepts input words, counts the batch, marks drops and overflow
// depends on ssrk_pkg
`default_nettype none

module ssrk_front import ssrk_pkg::*; #(
  parameter int unsigned MaxItems = DEFAULT_MAX_ITEMS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire in_word_t item_i,
  input  wire logic     q_full_i,
  output logic          full_o,
  output logic          q_push_o,
  output q_entry_t      q_entry_o
);

  localparam int unsigned CW = $clog2(MaxItems + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          accept, store;

  assign full_o = q_full_i;
  assign accept = push_i & ~q_full_i;
  assign store  = (cnt_q < CW'(MaxItems));

  always_comb begin
    q_entry_o.key   = item_i.record_key;
    q_entry_o.tag   = item_i.record_tag;
    q_entry_o.last  = item_i.last_item;
    q_entry_o.store = store;
    q_entry_o.ovf   = ovf_q | ~store;
    // dropped non-closing words never reach the back
    q_push_o = accept & (store | item_i.last_item);

    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (item_i.last_item) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (store) begin
        cnt_d = cnt_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ssrk_back.sv
// back part: insertion into a sorted record memory, then in-order readout
// depends on ssrk_pkg
`default_nettype none

module ssrk_back import ssrk_pkg::*; #(
  parameter int unsigned MaxItems = DEFAULT_MAX_ITEMS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire q_entry_t q_entry_i,
  input  wire logic     q_empty_i,
  output logic          q_pop_o,
  input  wire logic     pop_i,
  output logic          empty_o,
  output out_word_t     result_o
);

  localparam int unsigned AW = $clog2(MaxItems);
  localparam int unsigned CW = $clog2(MaxItems + 1);

  rec_t          mem_q [MaxItems];
  rec_t          rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  rec_t          mem_wdata;

  back_state_e   state_q, state_d;
  q_entry_t      cur_q, cur_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] held_q, held_d;
  logic          out_valid_q, out_valid_d;
  out_word_t     out_q, out_d;
  logic          is_final;

  assign empty_o  = ~out_valid_q;
  assign result_o = out_q;
  assign is_final = ((CW'(idx_q) + CW'(1)) == held_q);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    held_d      = held_q;
    out_valid_d = out_valid_q & ~pop_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = '{key: cur_q.key, tag: cur_q.tag};
    mem_re      = 1'b0;
    mem_raddr   = idx_q;

    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_entry_i;
          idx_d   = '0;
          if (q_entry_i.store) begin
            if (held_q == '0) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = '{key: q_entry_i.key, tag: q_entry_i.tag};
              held_d    = held_q + CW'(1);
              state_d   = q_entry_i.last ? B_EMIT_RD : B_IDLE;
            end else begin
              pos_d     = AW'(held_q);
              mem_re    = 1'b1;
              mem_raddr = AW'(held_q - CW'(1));
              state_d   = B_CMP;
            end
          end else begin
            state_d = B_EMIT_RD;
          end
        end
      end
      B_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        if (rd_q.key > cur_q.key) begin
          // shift the larger record up one slot
          mem_wdata = rd_q;
          pos_d     = pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            state_d = B_PLACE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pos_q - AW'(2);
          end
        end else begin
          held_d  = held_q + CW'(1);
          state_d = cur_q.last ? B_EMIT_RD : B_IDLE;
        end
      end
      B_PLACE: begin
        mem_we  = 1'b1;
        held_d  = held_q + CW'(1);
        state_d = cur_q.last ? B_EMIT_RD : B_IDLE;
      end
      B_EMIT_RD: begin
        mem_re  = 1'b1;
        state_d = B_EMIT_WAIT;
      end
      B_EMIT_WAIT: begin
        if (!out_valid_q || pop_i) begin
          out_valid_d        = 1'b1;
          out_d.sorted_key   = rd_q.key;
          out_d.sorted_tag   = rd_q.tag;
          out_d.final_result = is_final;
          out_d.overflowed   = cur_q.ovf;
          if (is_final) begin
            held_d  = '0;
            state_d = B_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = B_EMIT_RD;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    pos_q <= pos_d;
    idx_q <= idx_d;
    out_q <= out_d;
  end

  // record memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/stable_sort_records_by_key.sv
// top level of the batch record sorter: stable ascending sort by key
// depends on ssrk_pkg, ssrk_queue, ssrk_front, ssrk_back and the macros header
//
//   channel | direction | handshake         | word
//   input   | in        | push / full       | item_i   (in_word_t)
//   result  | out       | empty / pop       | result_o (out_word_t)
//
// the front takes one word per cycle while the queue has room
// inserting a record of a batch shifts every held record with a larger key up one slot
//   in the back, limited by the single read and single write port of the record memory
// readout passes through B_EMIT_RD and B_EMIT_WAIT for each result, and waits while the consumer stalls pop
// reset clears counters and state only; the record memory needs no clearing
// full follows the queue, so a stalled consumer backs up into the input side
`default_nettype none
`include "stable_sort_records_by_key_macros.svh"

module stable_sort_records_by_key import ssrk_pkg::*; #(
  parameter int unsigned MaxItems = DEFAULT_MAX_ITEMS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_word_t item_i,
  output logic          empty,
  input  wire logic     pop,
  output out_word_t     result_o
);

  // front to queue
  logic     q_push;
  q_entry_t q_in;
  // queue to back
  q_entry_t q_out;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  // front classifies each word: store, drop, or close the batch
  ssrk_front #(
    .MaxItems (MaxItems)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (item_i),
    .q_full_i  (q_full),
    .full_o    (full),
    .q_push_o  (q_push),
    .q_entry_o (q_in)
  );

  // decoupling queue so front and back stall independently
  ssrk_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .entry_o (q_out),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back keeps the batch sorted as it arrives and streams it out on close
  ssrk_back #(
    .MaxItems (MaxItems)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_entry_i (q_out),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result_o)
  );

  // tracking of the previous popped word within a batch, for checks only
  logic prev_valid_q, prev_valid_d;
  key_t prev_key_q, prev_key_d;
  logic prev_ovf_q, prev_ovf_d;

  always_comb begin
    prev_valid_d = prev_valid_q;
    prev_key_d   = prev_key_q;
    prev_ovf_d   = prev_ovf_q;
    if (pop && !empty) begin
      prev_valid_d = ~result_o.final_result;
      prev_key_d   = result_o.sorted_key;
      prev_ovf_d   = result_o.overflowed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q <= 1'b0;
      prev_key_q   <= '0;
      prev_ovf_q   <= 1'b0;
    end else begin
      prev_valid_q <= prev_valid_d;
      prev_key_q   <= prev_key_d;
      prev_ovf_q   <= prev_ovf_d;
    end
  end

  // results of one batch come out in ascending key order
  `SSRK_ASSERT_IMP(a_sorted_order, clk_i, rst_ni, !empty && prev_valid_q, result_o.sorted_key >= prev_key_q, "sorted keys out of order")
  // overflow flag is the same on every word of a batch
  `SSRK_ASSERT_IMP(a_ovf_steady, clk_i, rst_ni, !empty && prev_valid_q, result_o.overflowed == prev_ovf_q, "overflow flag changed within a batch")
  // a word written into the queue is visible to the back next cycle
  `SSRK_ASSERT_NEXT(a_queue_fill, clk_i, rst_ni, q_push, !q_empty, "queue lost a pushed word")

endmodule

`default_nettype wire
